// File: rtl/ftsc_pkg.sv
// ----------------------------------------------------------------------------
// ftsc_pkg
// shared types, type codes and signature constants of the file type classifier
// ----------------------------------------------------------------------------
package ftsc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_file_type;

    // result type codes
    localparam t_file_type FT_ELF      = 4'd0;
    localparam t_file_type FT_PNG      = 4'd1;
    localparam t_file_type FT_GZIP     = 4'd2;
    localparam t_file_type FT_BZIP2    = 4'd3;
    localparam t_file_type FT_XZ       = 4'd4;
    localparam t_file_type FT_ZIP      = 4'd5;
    localparam t_file_type FT_PDF      = 4'd6;
    localparam t_file_type FT_SCRIPT   = 4'd7;
    localparam t_file_type FT_SQUASHFS = 4'd8;
    localparam t_file_type FT_TAR      = 4'd9;
    localparam t_file_type FT_TEXT     = 4'd10;
    localparam t_file_type FT_DATA     = 4'd11;

    localparam int PREFIX_LEN = 5;
    localparam int TAR_OFFSET = 257;
    localparam int TAR_END    = 262;
    localparam int RESULT_W   = 9;

    // text check
    localparam t_byte CTRL_LIMIT = 8'h20;
    localparam t_byte CH_LF      = 8'h0a;
    localparam t_byte CH_CR      = 8'h0d;
    localparam t_byte CH_TAB     = 8'h09;
    localparam t_byte CH_ESC     = 8'h1b;

    // progress of one file's scan, as seen after the current byte
    typedef struct packed {
        t_byte [PREFIX_LEN-1:0] prefix;
        logic                   tar_ok;
        logic                   text_ok;
    } t_scan;

    // "ustar" at the tar magic offset
    function automatic t_byte tar_char(input logic [2:0] idx);
        t_byte c;
        unique case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/ftsc_byte_if.sv
// ----------------------------------------------------------------------------
// ftsc_byte_if
// header byte channel: valid/ready with one byte and an end-of-file flag
// ----------------------------------------------------------------------------
interface ftsc_byte_if;
    import ftsc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/ftsc_type_if.sv
// ----------------------------------------------------------------------------
// ftsc_type_if
// result channel: valid/ready with type code and examined byte count
// ----------------------------------------------------------------------------
interface ftsc_type_if;
    import ftsc_pkg::*;

    logic                valid;
    logic                ready;
    t_file_type          file_type;
    logic [RESULT_W-1:0] bytes_examined;

    modport source (output valid, output file_type, output bytes_examined, input ready);
    modport sink   (input valid, input file_type, input bytes_examined, output ready);
endinterface

// File: rtl/file_type_signature_classifier.sv
// ----------------------------------------------------------------------------
// file_type_signature_classifier
// magic number file type detection over a streamed file header
// ----------------------------------------------------------------------------
// Feed the header of a file one byte per request on i_byte, marking the final
// byte with last_byte. One request is taken every clock cycle while ready is
// high: each byte only updates the scan state (byte count, first five bytes,
// tar mark flag, text flag), and the request carrying last_byte is classified
// in that same cycle and its result lands in the output register, so that
// o_type.valid rises in the next cycle, with the scan state back to its reset
// value for the next file. Input ready is held low only while a result sits
// in the output register and o_type is not taking it. Bytes beyond the first
// HEADER_BYTES are swallowed without effect. Leading signatures are checked
// in order elf, png, gzip, bzip2, xz, zip, pdf, script shebang, squashfs,
// each only if the file was long enough; then "ustar" at offset 257 gives
// tar; otherwise any zero or control byte other than newline, return, tab or
// escape makes the file data, else text.
// bytes_examined carries the low nine bits of the examined count.
module file_type_signature_classifier #(
    parameter int HEADER_BYTES = 264
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ftsc_byte_if.sink   i_byte,
    ftsc_type_if.source o_type
);
    import ftsc_pkg::*;

    // count must be able to hold the limit itself
    localparam int CW = $clog2(HEADER_BYTES + 1);

    logic                take;
    t_scan               scan;
    logic [CW-1:0]       count;
    t_file_type          file_type;

    logic                r_out_valid;
    t_file_type          r_file_type;
    logic [RESULT_W-1:0] r_bytes;

    // output register frees up when the sink takes its result
    assign i_byte.ready = !r_out_valid || o_type.ready;
    assign take         = i_byte.valid && i_byte.ready;

    ftsc_track #(
        .HEADER_BYTES (HEADER_BYTES),
        .CW           (CW)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_byte.data_byte),
        .i_last  (i_byte.last_byte),
        .o_scan  (scan),
        .o_count (count)
    );

    // classification sees the state including the final byte
    ftsc_classify #(
        .CW (CW)
    ) u_classify (
        .i_scan      (scan),
        .i_count     (count),
        .o_file_type (file_type)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_byte.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_type.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take && i_byte.last_byte) begin
            r_file_type <= file_type;
            r_bytes     <= count[RESULT_W-1:0];
        end
    end

    assign o_type.valid          = r_out_valid;
    assign o_type.file_type      = r_file_type;
    assign o_type.bytes_examined = r_bytes;

endmodule

// File: rtl/ftsc_track.sv
// ----------------------------------------------------------------------------
// ftsc_track
// per-file scan state: byte count, leading bytes, tar mark and text flags
// ----------------------------------------------------------------------------
module ftsc_track #(
    parameter int HEADER_BYTES = 264,
    parameter int CW           = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  ftsc_pkg::t_byte i_data,
    input  logic            i_last,
    output ftsc_pkg::t_scan o_scan,
    output logic [CW-1:0]   o_count
);
    import ftsc_pkg::*;

    logic [CW-1:0] r_count, n_count;
    t_scan         r_scan,  n_scan;
    logic          active;
    logic          in_tar;
    logic [2:0]    tar_idx;
    logic [CW-1:0] tar_rel;

    assign active  = r_count < CW'(HEADER_BYTES);
    assign in_tar  = (r_count >= CW'(TAR_OFFSET)) && (r_count < CW'(TAR_END));
    assign tar_rel = r_count - CW'(TAR_OFFSET);
    assign tar_idx = tar_rel[2:0];

    // scan state including the byte on the input
    always_comb begin
        n_scan  = r_scan;
        n_count = r_count;
        if (i_take && active) begin
            if (r_count < CW'(PREFIX_LEN)) begin
                n_scan.prefix[r_count[2:0]] = i_data;
            end
            if (in_tar && (i_data != tar_char(tar_idx))) begin
                n_scan.tar_ok = 1'b0;
            end
            if ((i_data < CTRL_LIMIT) && (i_data != CH_LF) && (i_data != CH_CR)
                    && (i_data != CH_TAB) && (i_data != CH_ESC)) begin
                n_scan.text_ok = 1'b0;
            end
            n_count = r_count + CW'(1);
        end
    end

    assign o_scan  = n_scan;
    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_scan.prefix  <= '0;
            r_scan.tar_ok  <= 1'b1;
            r_scan.text_ok <= 1'b1;
        end else if (i_take) begin
            if (i_last) begin
                r_count        <= '0;
                r_scan.prefix  <= '0;
                r_scan.tar_ok  <= 1'b1;
                r_scan.text_ok <= 1'b1;
            end else begin
                r_count <= n_count;
                r_scan  <= n_scan;
            end
        end
    end

endmodule

// File: rtl/ftsc_classify.sv
// ----------------------------------------------------------------------------
// ftsc_classify
// signature priority match over the leading bytes, then tar, text or data
// ----------------------------------------------------------------------------
module ftsc_classify #(
    parameter int CW = 9
) (
    input  ftsc_pkg::t_scan      i_scan,
    input  logic [CW-1:0]        i_count,
    output ftsc_pkg::t_file_type o_file_type
);
    import ftsc_pkg::*;

    t_byte b0, b1, b2, b3, b4;
    logic  ge2, ge3, ge4, ge5, ge_tar;

    assign b0 = i_scan.prefix[0];
    assign b1 = i_scan.prefix[1];
    assign b2 = i_scan.prefix[2];
    assign b3 = i_scan.prefix[3];
    assign b4 = i_scan.prefix[4];

    assign ge2    = i_count >= CW'(2);
    assign ge3    = i_count >= CW'(3);
    assign ge4    = i_count >= CW'(4);
    assign ge5    = i_count >= CW'(5);
    assign ge_tar = i_count >= CW'(TAR_END);

    always_comb begin
        priority if (ge4 && b0 == 8'h7f && b1 == 8'h45 && b2 == 8'h4c && b3 == 8'h46) begin
            o_file_type = FT_ELF;
        end else if (ge4 && b0 == 8'h89 && b1 == 8'h50 && b2 == 8'h4e && b3 == 8'h47) begin
            o_file_type = FT_PNG;
        end else if (ge2 && b0 == 8'h1f && b1 == 8'h8b) begin
            o_file_type = FT_GZIP;
        end else if (ge3 && b0 == 8'h42 && b1 == 8'h5a && b2 == 8'h68) begin
            o_file_type = FT_BZIP2;
        end else if (ge5 && b0 == 8'hfd && b1 == 8'h37 && b2 == 8'h7a && b3 == 8'h58
                && b4 == 8'h5a) begin
            o_file_type = FT_XZ;
        end else if (ge4 && b0 == 8'h50 && b1 == 8'h4b && b2 == 8'h03 && b3 == 8'h04) begin
            o_file_type = FT_ZIP;
        end else if (ge4 && b0 == 8'h25 && b1 == 8'h50 && b2 == 8'h44 && b3 == 8'h46) begin
            o_file_type = FT_PDF;
        end else if (ge2 && b0 == 8'h23 && b1 == 8'h21) begin
            o_file_type = FT_SCRIPT;
        end else if (ge4 && b0 == 8'h68 && b1 == 8'h73 && b2 == 8'h71 && b3 == 8'h73) begin
            o_file_type = FT_SQUASHFS;
        end else if (ge_tar && i_scan.tar_ok) begin
            o_file_type = FT_TAR;
        end else if (i_scan.text_ok) begin
            o_file_type = FT_TEXT;
        end else begin
            o_file_type = FT_DATA;
        end
    end

endmodule
